// ===== rtl/edtt_pkg.sv =====
// Shared types and constants for the earliest-deadline timer table.
package edtt_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int US_PER_MS       = 1000;
    localparam int QUEUE_DEPTH     = 2;   // power of two

    localparam int TIME_W  = 64;
    localparam int DELAY_W = 32;
    localparam int TAG_W   = 32;
    localparam int SPAN_W  = DELAY_W + 10;   // delay_ms * 1000 fits in 42 bits
    localparam int NRES_W  = $clog2(MAX_RESULTS + 1);

    localparam logic CMD_ARM  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic KIND_ARM    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic STATUS_STORED = 1'b0;
    localparam logic STATUS_FULL   = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [DELAY_W-1:0] delay_ms;
        logic [TAG_W-1:0]   tag;
    } t_in;

    typedef struct packed {
        logic             kind;
        logic             status;
        logic [TAG_W-1:0] expired_tag;
        logic             last;
    } t_out;

    // Classified command as it waits in the queue.
    typedef struct packed {
        logic              cmd;
        logic [SPAN_W-1:0] span_us;
        logic [TAG_W-1:0]  tag;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ARM,
        S_SCAN,
        S_RESOLVE,
        S_FLUSH
    } t_back_state;

endpackage

// ===== rtl/earliest_deadline_timer_table.sv =====
// Arm: the engine walks the slots in order and stores into the first free one; the status beat says stored or full.
// Tick: the clock advances, then repeated scans each pick the earliest due timer, clear it and report its
// tag; the last beat is flagged, and at most MAX_RESULTS timers expire per tick.
// Three commands can wait (intake register, two queue entries); busy rises when all are taken.
// Synchronous reset clears all slot valid bits and the clock at once; no clearing pass.
// Result beats are one-cycle strobes; the receiver cannot stall.
module earliest_deadline_timer_table #(
    parameter int TABLE_SLOTS = edtt_pkg::TABLE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  edtt_pkg::t_in  i_item,
    output logic           o_res_vld,
    output edtt_pkg::t_out o_res
);

    logic           push;
    edtt_pkg::t_job push_job;
    logic           q_full;
    logic           q_vld;
    edtt_pkg::t_job q_job;
    logic           q_pop;

    edtt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    edtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    edtt_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (q_vld),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_res_vld (o_res_vld),
        .o_res     (o_res)
    );

endmodule

// ===== rtl/edtt_front.sv =====
// Command intake: accepts a beat, decodes it and converts the delay to microseconds.
module edtt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  edtt_pkg::t_in     i_item,
    input  logic              i_q_full,
    output logic              o_push,
    output edtt_pkg::t_job    o_job
);

    logic           r_vld;
    edtt_pkg::t_job r_job;
    edtt_pkg::t_job n_job;
    logic           load;

    assign busy   = r_vld & i_q_full;
    assign o_push = r_vld & ~i_q_full;
    assign o_job  = r_job;
    assign load   = start & ~busy;

    always_comb begin
        n_job.cmd     = i_item.cmd;
        n_job.tag     = i_item.tag;
        n_job.span_us = edtt_pkg::SPAN_W'(i_item.delay_ms)
                      * edtt_pkg::SPAN_W'(edtt_pkg::US_PER_MS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= n_job;
        end
    end

endmodule

// ===== rtl/edtt_queue.sv =====
// Short command queue between the intake and the table engine.
module edtt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  edtt_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_vld,
    output edtt_pkg::t_job o_job,
    input  logic           i_pop
);

    localparam int PTR_W = $clog2(edtt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(edtt_pkg::QUEUE_DEPTH + 1);

    edtt_pkg::t_job   r_mem [edtt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(edtt_pkg::QUEUE_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/edtt_back.sv =====
// Table engine: slot storage, microsecond clock, arm search and expiry scans.
module edtt_back #(
    parameter int TABLE_SLOTS = edtt_pkg::TABLE_SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_vld,
    input  edtt_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_res_vld,
    output edtt_pkg::t_out o_res
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int TW = edtt_pkg::TIME_W;
    localparam int GW = edtt_pkg::TAG_W;
    localparam int NW = edtt_pkg::NRES_W;

    edtt_pkg::t_back_state r_state;
    edtt_pkg::t_back_state n_state;

    logic [TW-1:0]          mem_dl  [TABLE_SLOTS];
    logic [GW-1:0]          mem_tag [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [TW-1:0]          r_now;
    edtt_pkg::t_job         r_job;
    logic [CW-1:0]          r_cnt;
    logic                   r_chk_vld;
    logic [IW-1:0]          r_chk_idx;
    logic [TW-1:0]          r_rd_dl;
    logic [GW-1:0]          r_rd_tag;
    logic                   r_found;
    logic [IW-1:0]          r_best_idx;
    logic [TW-1:0]          r_best_dl;
    logic [GW-1:0]          r_best_tag;
    logic                   r_pend_vld;
    logic [GW-1:0]          r_pend_tag;
    logic [NW-1:0]          r_nres;
    logic                   r_res_vld;
    edtt_pkg::t_out         r_res;

    logic                   n_res_vld;
    edtt_pkg::t_out         n_res;
    logic [IW-1:0]          cur_idx;
    logic                   slot_busy;
    logic                   arm_last;
    logic                   scan_end;
    logic                   scan_rd;
    logic                   upd_best;
    logic                   q_pop;
    logic                   arm_we;
    logic                   clr_slot;

    assign cur_idx   = r_cnt[IW-1:0];
    assign arm_last  = (r_cnt == CW'(TABLE_SLOTS - 1));
    assign scan_end  = (r_cnt == CW'(TABLE_SLOTS));
    assign scan_rd   = (r_state == edtt_pkg::S_SCAN) && (r_cnt < CW'(TABLE_SLOTS));
    assign slot_busy = (r_cnt < CW'(TABLE_SLOTS)) ? r_valid[cur_idx] : 1'b1;
    assign upd_best  = r_chk_vld && r_valid[r_chk_idx] && (r_rd_dl <= r_now)
                    && (!r_found || (r_rd_dl < r_best_dl));

    assign o_q_pop   = q_pop;
    assign o_res_vld = r_res_vld;
    assign o_res     = r_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            edtt_pkg::S_IDLE: begin
                if (i_q_vld) begin
                    n_state = (i_q_job.cmd == edtt_pkg::CMD_TICK) ? edtt_pkg::S_SCAN
                                                                   : edtt_pkg::S_ARM;
                end
            end
            edtt_pkg::S_ARM: begin
                if (!slot_busy || arm_last) begin
                    n_state = edtt_pkg::S_IDLE;
                end
            end
            edtt_pkg::S_SCAN: begin
                if (scan_end) begin
                    n_state = edtt_pkg::S_RESOLVE;
                end
            end
            edtt_pkg::S_RESOLVE: begin
                if (!r_found) begin
                    n_state = edtt_pkg::S_IDLE;
                end else if (r_nres == NW'(edtt_pkg::MAX_RESULTS - 1)) begin
                    n_state = edtt_pkg::S_FLUSH;
                end else begin
                    n_state = edtt_pkg::S_SCAN;
                end
            end
            edtt_pkg::S_FLUSH: begin
                n_state = edtt_pkg::S_IDLE;
            end
            default: begin
                n_state = edtt_pkg::S_IDLE;
            end
        endcase
    end

    // The previous expiry is held back until the next scan tells whether it is the last one.
    always_comb begin
        q_pop     = 1'b0;
        arm_we    = 1'b0;
        clr_slot  = 1'b0;
        n_res_vld = 1'b0;
        n_res     = '0;
        unique case (r_state)
            edtt_pkg::S_IDLE: begin
                q_pop = i_q_vld;
            end
            edtt_pkg::S_ARM: begin
                if (!slot_busy) begin
                    arm_we       = 1'b1;
                    n_res_vld    = 1'b1;
                    n_res.kind   = edtt_pkg::KIND_ARM;
                    n_res.status = edtt_pkg::STATUS_STORED;
                    n_res.last   = 1'b1;
                end else if (arm_last) begin
                    n_res_vld    = 1'b1;
                    n_res.kind   = edtt_pkg::KIND_ARM;
                    n_res.status = edtt_pkg::STATUS_FULL;
                    n_res.last   = 1'b1;
                end
            end
            edtt_pkg::S_SCAN: begin
                n_res_vld = 1'b0;
            end
            edtt_pkg::S_RESOLVE: begin
                clr_slot          = r_found;
                n_res_vld         = r_pend_vld;
                n_res.kind        = edtt_pkg::KIND_EXPIRY;
                n_res.status      = edtt_pkg::STATUS_STORED;
                n_res.expired_tag = r_pend_tag;
                n_res.last        = ~r_found;
            end
            edtt_pkg::S_FLUSH: begin
                n_res_vld         = 1'b1;
                n_res.kind        = edtt_pkg::KIND_EXPIRY;
                n_res.status      = edtt_pkg::STATUS_STORED;
                n_res.expired_tag = r_pend_tag;
                n_res.last        = 1'b1;
            end
            default: begin
                n_res_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= edtt_pkg::S_IDLE;
            r_valid    <= '0;
            r_now      <= '0;
            r_cnt      <= '0;
            r_chk_vld  <= 1'b0;
            r_found    <= 1'b0;
            r_pend_vld <= 1'b0;
            r_nres     <= '0;
            r_res_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            r_chk_vld <= scan_rd;
            if (q_pop) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
                if (i_q_job.cmd == edtt_pkg::CMD_TICK) begin
                    r_now      <= r_now + TW'(1);
                    r_nres     <= '0;
                    r_pend_vld <= 1'b0;
                end
            end
            if ((r_state == edtt_pkg::S_ARM && slot_busy && !arm_last)
                || (r_state == edtt_pkg::S_SCAN && !scan_end)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (upd_best) begin
                r_found <= 1'b1;
            end
            if (arm_we) begin
                r_valid[cur_idx] <= 1'b1;
            end
            if (clr_slot) begin
                r_valid[r_best_idx] <= 1'b0;
                r_pend_vld          <= 1'b1;
                r_nres              <= r_nres + NW'(1);
                r_cnt               <= '0;
                r_found             <= 1'b0;
            end
            if (r_state == edtt_pkg::S_FLUSH
                || (r_state == edtt_pkg::S_RESOLVE && !r_found)) begin
                r_pend_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_job <= i_q_job;
        end
        if (arm_we) begin
            mem_dl[cur_idx]  <= r_now + TW'(r_job.span_us);
            mem_tag[cur_idx] <= r_job.tag;
        end
        if (scan_rd) begin
            r_rd_dl   <= mem_dl[cur_idx];
            r_rd_tag  <= mem_tag[cur_idx];
            r_chk_idx <= cur_idx;
        end
        if (upd_best) begin
            r_best_idx <= r_chk_idx;
            r_best_dl  <= r_rd_dl;
            r_best_tag <= r_rd_tag;
        end
        if (clr_slot) begin
            r_pend_tag <= r_best_tag;
        end
        r_res <= n_res;
    end

endmodule
